[src/bsa_pkg.sv]
`timescale 1ns / 1ps

package bsa_pkg;

  // Bitmap geometry: WordCount words of WordBits slots each.
  localparam int WordCount = 16;
  localparam int WordBits  = 64;
  localparam int WordIdxW  = (WordCount > 1) ? $clog2(WordCount) : 1;
  localparam int BitIdxW   = $clog2(WordBits);
  localparam int SlotW     = 10;
  // Word part of a slot index as it arrives on the input.
  localparam int SlotWordW = SlotW - BitIdxW;

  typedef enum logic {
    OP_ALLOC   = 1'b0,
    OP_RELEASE = 1'b1
  } op_e;

  // Read request to the bitmap memory.
  typedef struct packed {
    logic                en;
    logic [WordIdxW-1:0] addr;
  } rd_req_t;

  // Write request to the bitmap memory.
  typedef struct packed {
    logic                en;
    logic [WordIdxW-1:0] addr;
    logic [WordBits-1:0] data;
  } wr_req_t;

  // One finished result word.
  typedef struct packed {
    logic             success;
    logic [SlotW-1:0] slot;
  } result_t;

  // Position of the lowest clear bit; an all-ones word gives the top position.
  function automatic logic [BitIdxW-1:0] lowest_zero(input logic [WordBits-1:0] word);
    logic [BitIdxW-1:0] pos;
    pos = BitIdxW'(WordBits - 1);
    for (int i = WordBits - 1; i >= 0; i--) begin
      if (!word[i]) begin
        pos = BitIdxW'(i);
      end
    end
    return pos;
  endfunction

endpackage

[src/bsa_bitmap_mem.sv]
`timescale 1ns / 1ps

module bsa_bitmap_mem (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  bsa_pkg::rd_req_t                     rd_req_i,
  input  bsa_pkg::wr_req_t                     wr_req_i,
  output logic [bsa_pkg::WordBits-1:0]         rd_data_o
);

  logic [bsa_pkg::WordBits-1:0]  mem_q [bsa_pkg::WordCount];
  logic [bsa_pkg::WordCount-1:0] written_q;
  logic [bsa_pkg::WordBits-1:0]  rd_data_q;
  logic                          rd_written_q;

  // Storage array; a write updates one whole word.
  always_ff @(posedge clk_i) begin
    if (wr_req_i.en) begin
      mem_q[wr_req_i.addr] <= wr_req_i.data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (rd_req_i.en) begin
      rd_data_q <= mem_q[rd_req_i.addr];
    end
  end

  // One flag per word; a word never written reads as all free.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q    <= '0;
      rd_written_q <= 1'b0;
    end else begin
      if (wr_req_i.en) begin
        written_q[wr_req_i.addr] <= 1'b1;
      end
      if (rd_req_i.en) begin
        rd_written_q <= written_q[rd_req_i.addr];
      end
    end
  end

  assign rd_data_o = rd_written_q ? rd_data_q : '0;

endmodule

[src/bsa_ctrl.sv]
`timescale 1ns / 1ps

module bsa_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  bsa_pkg::op_e                 in_op_i,
  input  logic [bsa_pkg::SlotW-1:0]    in_slot_i,
  output bsa_pkg::rd_req_t             rd_req_o,
  output bsa_pkg::wr_req_t             wr_req_o,
  input  logic [bsa_pkg::WordBits-1:0] rd_data_i,
  output logic                         res_valid_o,
  input  logic                         res_ready_i,
  output bsa_pkg::result_t             res_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StScan = 2'd1;
  localparam logic [1:0] StResp = 2'd2;

  localparam logic [bsa_pkg::WordIdxW-1:0] LastWord =
    bsa_pkg::WordIdxW'(bsa_pkg::WordCount - 1);

  logic [1:0]                      state_q, state_d;
  bsa_pkg::op_e                    op_q, op_d;
  logic [bsa_pkg::SlotW-1:0]       slot_q, slot_d;
  logic [bsa_pkg::WordIdxW-1:0]    addr_q, addr_d;
  logic [bsa_pkg::WordIdxW-1:0]    hint_q, hint_d;
  bsa_pkg::result_t                res_q, res_d;

  logic [bsa_pkg::SlotWordW-1:0]   in_word;
  logic [bsa_pkg::BitIdxW-1:0]     rel_bit;
  logic [bsa_pkg::BitIdxW-1:0]     free_bit;
  logic [bsa_pkg::WordBits-1:0]    bit_mask;
  logic [bsa_pkg::WordIdxW+bsa_pkg::BitIdxW-1:0] grant_full;

  assign in_word  = in_slot_i[bsa_pkg::SlotW-1:bsa_pkg::BitIdxW];
  assign rel_bit  = slot_q[bsa_pkg::BitIdxW-1:0];
  assign free_bit = bsa_pkg::lowest_zero(rd_data_i);
  assign bit_mask = bsa_pkg::WordBits'(1) << ((op_q == bsa_pkg::OP_RELEASE) ? rel_bit : free_bit);
  assign grant_full = {addr_q, free_bit};

  // Sequencer: read a word, then modify and write it back or move on to the next one.
  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    slot_d   = slot_q;
    addr_d   = addr_q;
    hint_d   = hint_q;
    res_d    = res_q;
    rd_req_o = '0;
    wr_req_o = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          op_d   = in_op_i;
          slot_d = in_slot_i;
          if (in_op_i == bsa_pkg::OP_ALLOC) begin
            rd_req_o.en   = 1'b1;
            rd_req_o.addr = hint_q;
            addr_d        = hint_q;
            state_d       = StScan;
          end else if (int'(in_word) >= bsa_pkg::WordCount) begin
            // Slot beyond the bitmap: echoed with a failure flag.
            res_d.success = 1'b0;
            res_d.slot    = in_slot_i;
            state_d       = StResp;
          end else begin
            rd_req_o.en   = 1'b1;
            rd_req_o.addr = bsa_pkg::WordIdxW'(in_word);
            addr_d        = bsa_pkg::WordIdxW'(in_word);
            state_d       = StScan;
          end
        end
      end
      StScan: begin
        if (op_q == bsa_pkg::OP_RELEASE) begin
          if ((rd_data_i & bit_mask) != '0) begin
            wr_req_o.en   = 1'b1;
            wr_req_o.addr = addr_q;
            wr_req_o.data = rd_data_i & ~bit_mask;
            if (addr_q < hint_q) begin
              hint_d = addr_q;
            end
          end
          res_d.success = 1'b1;
          res_d.slot    = slot_q;
          state_d       = StResp;
        end else if (rd_data_i != '1) begin
          wr_req_o.en   = 1'b1;
          wr_req_o.addr = addr_q;
          wr_req_o.data = rd_data_i | bit_mask;
          hint_d        = addr_q;
          res_d.success = 1'b1;
          res_d.slot    = bsa_pkg::SlotW'(grant_full);
          state_d       = StResp;
        end else if (addr_q == LastWord) begin
          // Every word from the hint up is full.
          res_d.success = 1'b0;
          res_d.slot    = '0;
          state_d       = StResp;
        end else begin
          rd_req_o.en   = 1'b1;
          rd_req_o.addr = addr_q + 1'b1;
          addr_d        = addr_q + 1'b1;
        end
      end
      StResp: begin
        if (res_ready_i) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      hint_q  <= '0;
    end else begin
      state_q <= state_d;
      hint_q  <= hint_d;
    end
  end

  // Working registers of the current word.
  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    slot_q <= slot_d;
    addr_q <= addr_d;
    res_q  <= res_d;
  end

  assign in_ready_o  = (state_q == StIdle);
  assign res_valid_o = (state_q == StResp);
  assign res_o       = res_q;

endmodule

[src/bitmap_slot_allocator.sv]
`timescale 1ns / 1ps

// First-fit slot allocator over a 1024-slot bitmap held in a 16 x 64-bit
// synchronous memory. Input word: tuser is the operation (0 allocate,
// 1 release), tdata carries the slot to release. Output word: tuser is the
// success flag, tdata the granted or echoed slot (0 on a failed allocation).
// One word is handled at a time. A release reads the bitmap word of its slot
// and writes it back cleared if the slot was taken; an allocation reads k
// bitmap words, where k (1 to 16) is the number of words read, one per cycle
// through the single memory read port, starting at the hint word. A new word is accepted as soon as the
// previous result has moved to the output register, even if it is not yet taken.
module bitmap_slot_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [9:0] slot_to_release, [15:10] zero
  input  logic        s_axis_tuser,   // [0] operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [9:0] slot_index, [15:10] zero
  output logic        m_axis_tuser    // [0] success
);

  bsa_pkg::rd_req_t             rd_req;
  bsa_pkg::wr_req_t             wr_req;
  logic [bsa_pkg::WordBits-1:0] rd_data;
  logic                         res_valid;
  logic                         res_ready;
  bsa_pkg::result_t             res;
  logic                         out_valid_q;
  bsa_pkg::result_t             out_res_q;

  bsa_bitmap_mem u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_req_i  (rd_req),
    .wr_req_i  (wr_req),
    .rd_data_o (rd_data)
  );

  bsa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_op_i     (bsa_pkg::op_e'(s_axis_tuser)),
    .in_slot_i   (s_axis_tdata[bsa_pkg::SlotW-1:0]),
    .rd_req_o    (rd_req),
    .wr_req_o    (wr_req),
    .rd_data_i   (rd_data),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // Output register between the sequencer and the downstream side.
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_res_q.success;
  assign m_axis_tdata  = 16'(out_res_q.slot);

  // An accepted word keeps the input closed until its result is out.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted twice in a row");

  // A failed allocation reports slot zero.
  a_fail_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (out_res_q.slot == '0))
    else $error("failed result with a non-zero slot");

  // The bitmap is written back only while a word is in work.
  a_write_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_req.en |-> (!s_axis_tready && !res_valid))
    else $error("bitmap written outside a scan");

  // A write-back always follows a read of the same word.
  a_write_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_req.en |-> ($past(rd_req.en) && ($past(rd_req.addr) == wr_req.addr)))
    else $error("bitmap write without matching read");

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps

module testbench;

  localparam int QuietLimit = 4000;
  localparam int HoldCycles = 300;
  localparam int DrainCycles = 40;

  // Scoreboard: mirrors the occupancy bitmap and the search hint, and keeps
  // the results still owed by the block in order of acceptance.
  class slot_scoreboard;
    logic [bsa_pkg::WordBits-1:0] occupancy [bsa_pkg::WordCount];
    int unsigned                  search_word;
    bsa_pkg::result_t             owed [$];
    int unsigned                  errors;

    function new();
      foreach (occupancy[w]) occupancy[w] = '0;
      search_word = 0;
      errors = 0;
    endfunction

    function bit is_taken(logic [bsa_pkg::SlotW-1:0] slot);
      int unsigned w;
      w = slot / bsa_pkg::WordBits;
      if (w >= bsa_pkg::WordCount) return 1'b0;
      return occupancy[w][slot % bsa_pkg::WordBits];
    endfunction

    // Work out the result of one accepted request and update the mirror.
    function void note_request(bsa_pkg::op_e op, logic [bsa_pkg::SlotW-1:0] slot);
      bsa_pkg::result_t res;
      int unsigned      w;
      int unsigned      b;
      bit               found;
      res = '0;
      found = 1'b0;
      if (op == bsa_pkg::OP_ALLOC) begin
        for (w = search_word; w < bsa_pkg::WordCount && !found; w++) begin
          if (occupancy[w] != {bsa_pkg::WordBits{1'b1}}) begin
            b = 0;
            while (occupancy[w][b]) b++;
            occupancy[w][b] = 1'b1;
            search_word = w;
            res.success = 1'b1;
            res.slot = bsa_pkg::SlotW'(w * bsa_pkg::WordBits + b);
            found = 1'b1;
          end
        end
      end else begin
        w = slot / bsa_pkg::WordBits;
        b = slot % bsa_pkg::WordBits;
        res.slot = slot;
        if (w < bsa_pkg::WordCount) begin
          res.success = 1'b1;
          if (occupancy[w][b]) begin
            occupancy[w][b] = 1'b0;
            if (w < search_word) search_word = w;
          end
        end
      end
      owed.push_back(res);
    endfunction

    function void flag(string what);
      errors++;
      if (errors <= 10) $display("%t mismatch: %s", $realtime, what);
    endfunction

    // Compare one accepted output word with the oldest owed result.
    function void check_result(logic success, logic [bsa_pkg::SlotW-1:0] slot);
      bsa_pkg::result_t want;
      if (owed.size() == 0) begin
        flag($sformatf("unexpected word success=%b slot=%0d", success, slot));
        return;
      end
      want = owed.pop_front();
      if (success !== want.success || slot !== want.slot) begin
        flag($sformatf("expected success=%b slot=%0d, got success=%b slot=%0d",
                       want.success, want.slot, success, slot));
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tuser;

  slot_scoreboard ledger = new();

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  logic        hold_req;
  bit          hold_taken = 1'b0;

  bitmap_slot_allocator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  // Offer one request word, after a random gap, and wait for its handshake.
  task automatic send_request(input bsa_pkg::op_e op,
                              input logic [bsa_pkg::SlotW-1:0] slot);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= 16'(slot);
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    ledger.note_request(op, slot);
  endtask

  // Hold the sender back until every owed result has come out.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (ledger.owed.size() != 0) @(posedge clk_i);
  endtask

  // Release target: mostly slots in use, some anywhere, some at the borders.
  function automatic logic [bsa_pkg::SlotW-1:0] pick_release_slot();
    logic [bsa_pkg::SlotW-1:0] slot;
    int unsigned               k;
    k = $urandom_range(99);
    slot = bsa_pkg::SlotW'($urandom);
    if (k < 20) begin
      case ($urandom_range(5))
        0: slot = '0;
        1: slot = bsa_pkg::SlotW'(bsa_pkg::WordBits - 1);
        2: slot = bsa_pkg::SlotW'(bsa_pkg::WordBits);
        3: slot = bsa_pkg::SlotW'(511);
        4: slot = bsa_pkg::SlotW'(512);
        default: slot = {bsa_pkg::SlotW{1'b1}};
      endcase
    end else if (k < 70) begin
      repeat (32) if (!ledger.is_taken(slot)) slot = bsa_pkg::SlotW'($urandom);
    end
    return slot;
  endfunction

  task automatic send_random(input int unsigned alloc_pct);
    if ($urandom_range(99) < alloc_pct) begin
      send_request(bsa_pkg::OP_ALLOC, bsa_pkg::SlotW'($urandom));
    end else begin
      send_request(bsa_pkg::OP_RELEASE, pick_release_slot());
    end
  endtask

  // Receiver: random stalls, plus one long hold-off when the sender asks.
  initial begin : receiver
    int unsigned hold_left;
    hold_left = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Output monitor.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      ledger.check_result(m_axis_tuser, m_axis_tdata[bsa_pkg::SlotW-1:0]);
    end
  end

  // Watchdog on cycles without any handshake.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("testbench: errors");
    $finish;
  end

  initial begin : stimulus
    int unsigned phase_items [4];
    int unsigned phase_send [4];
    int unsigned phase_stall [4];
    int unsigned phase_alloc [4];
    phase_items = '{320, 320, 320, 230};
    phase_send  = '{0, 49, 0, 36};
    phase_stall = '{0, 0, 49, 36};
    phase_alloc = '{98, 98, 98, 80};

    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= bsa_pkg::OP_ALLOC;
    hold_req      <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: first grants, reuse of a freed slot, releases of free slots,
    // border slot numbers and an ignored data field on allocation.
    send_request(bsa_pkg::OP_ALLOC, '0);
    send_request(bsa_pkg::OP_ALLOC, {bsa_pkg::SlotW{1'b1}});
    send_request(bsa_pkg::OP_ALLOC, '0);
    send_request(bsa_pkg::OP_RELEASE, bsa_pkg::SlotW'(1));
    send_request(bsa_pkg::OP_ALLOC, 10'h155);
    send_request(bsa_pkg::OP_RELEASE, {bsa_pkg::SlotW{1'b1}});
    send_request(bsa_pkg::OP_RELEASE, '0);
    send_request(bsa_pkg::OP_RELEASE, '0);
    send_request(bsa_pkg::OP_ALLOC, 10'h2AA);
    send_request(bsa_pkg::OP_RELEASE, bsa_pkg::SlotW'(bsa_pkg::WordBits - 1));
    send_request(bsa_pkg::OP_RELEASE, bsa_pkg::SlotW'(bsa_pkg::WordBits));
    send_request(bsa_pkg::OP_RELEASE, bsa_pkg::SlotW'(512));
    send_request(bsa_pkg::OP_RELEASE, 10'h155);
    send_request(bsa_pkg::OP_RELEASE, 10'h2AA);
    send_request(bsa_pkg::OP_RELEASE, bsa_pkg::SlotW'(2));
    send_request(bsa_pkg::OP_ALLOC, '0);
    send_request(bsa_pkg::OP_ALLOC, '0);
    wait_drained();

    // Random phases; the bitmap fills up over the first three and the last
    // one churns around a full bitmap, with failed allocations.
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = phase_send[p];
      stall_pct = phase_stall[p];
      for (int i = 0; i < phase_items[p]; i++) begin
        if (p == 0 && i == 100) hold_req <= 1'b1;
        send_random(phase_alloc[p]);
      end
      wait_drained();
    end

    repeat (DrainCycles) @(posedge clk_i);
    if (ledger.owed.size() != 0) begin
      ledger.flag($sformatf("%0d results never came out", ledger.owed.size()));
    end
    if (ledger.errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
